// File: hdl/rsnh_pkg.sv
// shared types and constants for the ray segment nearest hit block
`default_nettype none
package rsnh_pkg;

  // one input transfer
  typedef struct packed {
    logic               action;
    logic [7:0]         edge_index;
    logic signed [15:0] edge_start_x;
    logic signed [15:0] edge_start_y;
    logic signed [15:0] edge_end_x;
    logic signed [15:0] edge_end_y;
    logic signed [15:0] ray_x;
    logic signed [15:0] ray_y;
    logic [15:0]        heading;
    logic [15:0]        beam_angle;
  } item_t;

  // one result transfer
  typedef struct packed {
    logic        hit;
    logic [16:0] distance;
  } result_t;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_CAST  = 1'b1;

  // quarter sine polynomial coefficients
  localparam logic [16:0] SIN_A = 17'd102944;
  localparam logic [16:0] SIN_B = 17'd42047;
  localparam logic [12:0] SIN_C = 13'd4640;
  localparam logic [14:0] QUARTER_TURN = 15'd16384;

  localparam logic [16:0] DIST_MAX = 17'd131071;

  // width of the big multiplier operands
  localparam int MUL_W = 34;
  // width of the division remainder
  localparam int REM_W = 70;

  typedef enum logic [4:0] {
    S_IDLE,
    S_TRIG_SQ,
    S_TRIG_U,
    S_TRIG_W,
    S_TRIG_S,
    S_READ,
    S_LOAD,
    S_PROD,
    S_TEST,
    S_MUL1,
    S_MUL2,
    S_NUM,
    S_NUMCHK,
    S_DIV,
    S_BEST,
    S_NEXT,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

// File: hdl/ray_segment_nearest_hit.sv
// top level: edge table memory and the cast sequencer
// a write transfer takes effect at its accepting edge and leaves busy low
// a cast first works out the direction, then per visited edge runs the side test, which may
// reject it, else two multiplies and the numerator sign test, which may reject it, else a divide
// done then strobes for 1 cycle, results cannot be held off, next transfer in the cycle after
// reset clears edge_count and the sequencer; table contents stay undefined
`default_nettype none
module ray_segment_nearest_hit #(
  parameter int MAX_EDGES       = 256,
  parameter int TRIG_TABLE_BITS = 10
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  rsnh_pkg::item_t   item,
  input  logic              cfg_we,
  input  logic [8:0]        cfg_wdata,
  output logic              done,
  output rsnh_pkg::result_t result
);
  import rsnh_pkg::*;

  localparam int AW       = $clog2(MAX_EDGES);
  localparam int CW       = AW + 1;
  localparam int NW       = (CW > 9) ? CW : 9;
  localparam int LOW_BITS = 16 - TRIG_TABLE_BITS;
  localparam logic [15:0] ANGLE_MASK = 16'(17'h0FFFF << LOW_BITS);

  state_t state, state_next;

  logic [8:0]  edge_count;
  logic [63:0] mem [MAX_EDGES];
  logic [63:0] rd_data;
  logic [CW-1:0] idx;
  logic [CW-1:0] n_lim;
  logic [NW-1:0] cnt_ext;

  logic accept;
  logic wr_en;

  // direction setup registers
  logic signed [15:0] ox, oy;
  logic [1:0]  quad;
  logic [13:0] r;
  logic        pass;
  logic [14:0] t, t2, s;
  logic [15:0] u;
  logic [16:0] w;
  logic signed [15:0] dx, dy;

  // per edge registers
  logic signed [16:0] px1, py1, px2, py2;
  logic [2:0]  j;
  logic signed [33:0] h1, h2, v1, v2;
  logic signed [2*MUL_W-1:0] m1, m2;
  logic signed [68:0] num;
  logic signed [34:0] den;
  logic [REM_W-1:0] rem, dsh;
  logic [4:0]  k;
  logic [17:0] q;
  logic        found;
  logic [16:0] best;

  // multiplier hookup
  logic mul_start, mul_done;
  logic signed [MUL_W-1:0] mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  // small combinational products
  logic [29:0] p_sq;
  logic [27:0] p_u;
  logic [30:0] p_w;
  logic [31:0] p_s;
  logic signed [15:0] ma;
  logic signed [16:0] mb;
  logic signed [32:0] sp;

  logic [15:0] angle;
  logic        skip_side, skip_num, div_ge;
  logic [16:0] q_sat;
  logic signed [16:0] ex0, ey0, ex1, ey1;

  assign accept = start && !busy;
  assign wr_en  = accept && (item.action == ACT_WRITE) && (int'(item.edge_index) < MAX_EDGES);
  assign angle  = (item.heading + item.beam_angle) & ANGLE_MASK;

  // edges visited per cast
  assign cnt_ext = NW'(edge_count);
  assign n_lim   = (cnt_ext > NW'(MAX_EDGES)) ? CW'(MAX_EDGES) : CW'(cnt_ext);

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      edge_count <= '0;
    end else if (cfg_we) begin
      edge_count <= cfg_wdata;
    end
  end

  // edge table, one write port and one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(item.edge_index)] <= {item.edge_start_x, item.edge_start_y,
                                    item.edge_end_x, item.edge_end_y};
    end
    rd_data <= mem[idx[AW-1:0]];
  end

  rsnh_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  // quarter sine steps
  assign p_sq = 30'(t) * 30'(t);
  assign p_u  = 28'(SIN_C) * 28'(t2);
  assign p_w  = 31'(u) * 31'(t2);
  assign p_s  = 32'(w) * 32'(t);

  // one small product per cycle for the cross and dot terms
  always_comb begin
    ma = j[0] ? dy : dx;
    unique case (j)
      3'd0: mb = py1;
      3'd1: mb = px1;
      3'd2: mb = py2;
      3'd3: mb = px2;
      3'd4: mb = px1;
      3'd5: mb = py1;
      3'd6: mb = px2;
      default: mb = py2;
    endcase
    sp = 33'(ma) * 33'(mb);
  end

  // edge rejection tests
  assign skip_side = ((!h1[33] && (h1 != 0)) && (!h2[33] && (h2 != 0))) ||
                     (h1[33] && h2[33]) || (h1 == h2);
  assign skip_num  = (num == 0) || (num[68] != den[34]);
  assign div_ge    = rem >= dsh;
  assign q_sat     = q[17] ? DIST_MAX : q[16:0];

  assign ex0 = 17'(signed'(rd_data[63:48]));
  assign ey0 = 17'(signed'(rd_data[47:32]));
  assign ex1 = 17'(signed'(rd_data[31:16]));
  assign ey1 = 17'(signed'(rd_data[15:0]));

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (accept && (item.action == ACT_CAST)) state_next = S_TRIG_SQ;
      S_TRIG_SQ: state_next = S_TRIG_U;
      S_TRIG_U:  state_next = S_TRIG_W;
      S_TRIG_W:  state_next = S_TRIG_S;
      S_TRIG_S: begin
        if (!pass) state_next = S_TRIG_SQ;
        else if (n_lim == 0) state_next = S_DONE;
        else state_next = S_READ;
      end
      S_READ:    state_next = S_LOAD;
      S_LOAD:    state_next = S_PROD;
      S_PROD:    if (j == 3'd7) state_next = S_TEST;
      S_TEST:    state_next = skip_side ? S_NEXT : S_MUL1;
      S_MUL1:    if (mul_done) state_next = S_MUL2;
      S_MUL2:    if (mul_done) state_next = S_NUM;
      S_NUM:     state_next = S_NUMCHK;
      S_NUMCHK:  state_next = skip_num ? S_NEXT : S_DIV;
      S_DIV:     if (k == 5'd17) state_next = S_BEST;
      S_BEST:    state_next = S_NEXT;
      S_NEXT:    state_next = (idx + 1'b1 == n_lim) ? S_DONE : S_READ;
      S_DONE:    state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // outputs and multiplier control
  always_comb begin
    busy      = (state != S_IDLE);
    done      = (state == S_DONE);
    mul_start = ((state == S_TEST) && !skip_side) || ((state == S_MUL1) && mul_done);
    mul_a     = (state == S_TEST) ? v1 : v2;
    mul_b     = (state == S_TEST) ? h2 : h1;
    result.hit      = found;
    result.distance = found ? best : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // found flag and visit index
  always_ff @(posedge clk) begin
    if (rst) begin
      found <= 1'b0;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept && (item.action == ACT_CAST)) begin
            found <= 1'b0;
            idx   <= '0;
          end
        end
        S_BEST:  if (!found || (q_sat < best)) found <= 1'b1;
        S_NEXT:  idx <= idx + 1'b1;
        default: ;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        ox   <= item.ray_x;
        oy   <= item.ray_y;
        quad <= angle[15:14];
        r    <= angle[13:0];
        t    <= {1'b0, angle[13:0]};
        pass <= 1'b0;
      end
      S_TRIG_SQ: t2 <= p_sq[28:14];
      S_TRIG_U:  u  <= 16'(SIN_B - 17'(p_u[27:14]));
      S_TRIG_W:  w  <= SIN_A - p_w[30:14];
      S_TRIG_S: begin
        if (!pass) begin
          s    <= p_s[30:16];
          t    <= QUARTER_TURN - {1'b0, r};
          pass <= 1'b1;
        end else begin
          unique case (quad)
            2'd0: begin dx <= 16'(p_s[30:16]); dy <= 16'(s); end
            2'd1: begin dx <= -16'(s); dy <= 16'(p_s[30:16]); end
            2'd2: begin dx <= -16'(p_s[30:16]); dy <= -16'(s); end
            default: begin dx <= 16'(s); dy <= -16'(p_s[30:16]); end
          endcase
        end
      end
      S_LOAD: begin
        px1 <= ex0 - 17'(ox);
        py1 <= ey0 - 17'(oy);
        px2 <= ex1 - 17'(ox);
        py2 <= ey1 - 17'(oy);
        j   <= '0;
      end
      S_PROD: begin
        j <= j + 1'b1;
        unique case (j)
          3'd0: h1 <= 34'(sp);
          3'd1: h1 <= h1 - 34'(sp);
          3'd2: h2 <= 34'(sp);
          3'd3: h2 <= h2 - 34'(sp);
          3'd4: v1 <= 34'(sp);
          3'd5: v1 <= v1 + 34'(sp);
          3'd6: v2 <= 34'(sp);
          default: v2 <= v2 + 34'(sp);
        endcase
      end
      S_MUL1: if (mul_done) m1 <= mul_p;
      S_MUL2: if (mul_done) m2 <= mul_p;
      S_NUM: begin
        num <= 69'(m1) - 69'(m2);
        den <= 35'(h2) - 35'(h1);
      end
      S_NUMCHK: begin
        rem <= num[68] ? REM_W'(-num) : REM_W'(num);
        dsh <= (den[34] ? REM_W'(-den) : REM_W'(den)) << 31;
        k   <= '0;
        q   <= '0;
      end
      S_DIV: begin
        if (div_ge) rem <= rem - dsh;
        dsh <= dsh >> 1;
        q   <= {q[16:0], div_ge};
        k   <= k + 1'b1;
      end
      S_BEST: if (!found || (q_sat < best)) best <= q_sat;
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: hdl/rsnh_mul.sv
// iterative signed multiplier, one multiplier bit per cycle
`default_nettype none
module rsnh_mul (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  input  logic signed [rsnh_pkg::MUL_W-1:0]   a,
  input  logic signed [rsnh_pkg::MUL_W-1:0]   b,
  output logic                                done,
  output logic signed [2*rsnh_pkg::MUL_W-1:0] product
);
  import rsnh_pkg::*;

  localparam int CNT_W = $clog2(MUL_W);

  logic               running;
  logic [CNT_W-1:0]   cnt;
  logic [MUL_W-1:0]   mplier;
  logic [2*MUL_W-1:0] mcand;
  logic [2*MUL_W-1:0] acc;
  logic               neg;
  logic [MUL_W-1:0]   a_mag;
  logic [MUL_W-1:0]   b_mag;

  // operand magnitudes
  assign a_mag = a[MUL_W-1] ? MUL_W'(-a) : MUL_W'(a);
  assign b_mag = b[MUL_W-1] ? MUL_W'(-b) : MUL_W'(b);

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(MUL_W - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // shift and add datapath
  always_ff @(posedge clk) begin
    if (start) begin
      mplier <= b_mag;
      mcand  <= (2*MUL_W)'(a_mag);
      acc    <= '0;
      neg    <= a[MUL_W-1] ^ b[MUL_W-1];
    end else if (running) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= mcand << 1;
      mplier <= mplier >> 1;
    end
  end

  assign product = neg ? -$signed(acc) : $signed(acc);

endmodule
`default_nettype wire

// File: hdl/rsnh_checker.sv
// port level checks for the ray segment nearest hit block
`default_nettype none
module rsnh_checker (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              start,
  input wire logic              busy,
  input wire rsnh_pkg::item_t   item,
  input wire logic              done,
  input wire rsnh_pkg::result_t result
);
  import rsnh_pkg::*;

  // a result only appears while a cast is in progress
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // a miss reports zero distance
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    (done && !result.hit) |-> (result.distance == 0))
    else $error("miss with nonzero distance");

  // a table write never occupies the block
  a_write_free: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.action == ACT_WRITE)) |=> !busy)
    else $error("write transfer made the block busy");

  // a cast transfer occupies the block
  a_cast_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (item.action == ACT_CAST)) |=> busy)
    else $error("cast transfer did not start");

  // the block frees up right after its result
  a_done_free: assert property (@(posedge clk) disable iff (rst) done |=> (!busy && !done))
    else $error("block still busy after result");

endmodule

bind ray_segment_nearest_hit rsnh_checker u_rsnh_checker (
  .clk    (clk),
  .rst    (rst),
  .start  (start),
  .busy   (busy),
  .item   (item),
  .done   (done),
  .result (result)
);
`default_nettype wire
